/* design/sdiv_pkg.sv */
package sdiv_pkg;

    // Loop length and counter widths
    localparam int unsigned STEPS   = 16;
    localparam int unsigned STEP_W  = 4;
    localparam int unsigned WORDS_W = 7;

    localparam logic [STEP_W-1:0]  LAST_STEP   = STEP_W'(STEPS - 1);
    localparam logic [7:0]         TRAP_COUNT  = 8'd4;
    localparam logic [WORDS_W-1:0] WORDS_POS   = 7'd6;
    localparam logic [WORDS_W-1:0] WORDS_NEG   = 7'd7;
    localparam logic [WORDS_W-1:0] WORDS_OVF   = 7'd2;
    localparam logic [WORDS_W-1:0] WORDS_TAKEN = 7'd3;
    localparam logic [WORDS_W-1:0] WORDS_KEPT  = 7'd4;
    localparam logic [WORDS_W-1:0] FIX_PP      = 7'd5;
    localparam logic [WORDS_W-1:0] FIX_PN      = 7'd7;
    localparam logic [WORDS_W-1:0] FIX_NX      = 7'd6;

    typedef enum logic [1:0] {
        OUT_DONE     = 2'd0,
        OUT_OVERFLOW = 2'd1,
        OUT_TRAP     = 2'd2
    } outcome_t;

    typedef struct packed {
        logic signed [31:0] dividend;
        logic signed [15:0] divisor;
    } in_word_t;

    typedef struct packed {
        logic [31:0] result_word;
        outcome_t    outcome;
        logic        quotient_negative;
        logic        quotient_zero;
        logic [7:0]  cycle_count;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic last_step;
        logic finish_early;
        logic finish_loop;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic dvs_zero;
        logic early_ovf;
    } status_t;

endpackage

/* design/sdiv_ifs.sv */
interface sdiv_in_if;
    logic                valid;
    logic                ready;
    sdiv_pkg::in_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sdiv_out_if;
    logic                valid;
    logic                ready;
    sdiv_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/sdiv_datapath.sv */
module sdiv_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sdiv_pkg::cmd_t      cmd,
    output sdiv_pkg::status_t   status,
    input  sdiv_pkg::in_word_t  in_data,
    output sdiv_pkg::out_word_t out_data
);
    import sdiv_pkg::*;

    logic [31:0]        dvd_reg;
    logic [15:0]        dvs_reg;
    logic [15:0]        mag_dvs_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        quo_reg;
    logic               dvd_neg_reg;
    logic               dvs_neg_reg;
    logic [WORDS_W-1:0] words_reg;
    out_word_t          fin_reg;
    out_word_t          out_reg;

    logic [31:0]        mag_dvd;
    logic [15:0]        rem_sh;
    logic [15:0]        quo_sh;
    logic               took;
    logic [15:0]        rem_next;
    logic [15:0]        quo_next;
    logic [WORDS_W-1:0] words_next;
    logic [15:0]        neg_quo;
    logic [15:0]        neg_rem;
    logic [15:0]        res_q;
    logic [15:0]        res_r;
    logic [WORDS_W-1:0] words_fix;
    logic               late_ovf;
    out_word_t          fin_next;

    // Magnitude of the dividend
    assign mag_dvd = dvd_reg[31] ? (32'd0 - dvd_reg) : dvd_reg;

    // One restoring shift-subtract step
    always_comb
    begin
        rem_sh = {rem_reg[14:0], quo_reg[15]};
        quo_sh = {quo_reg[14:0], 1'b0};
        took   = (rem_sh >= mag_dvs_reg);
        rem_next = took ? (rem_sh - mag_dvs_reg) : rem_sh;
        quo_next = {quo_sh[15:1], took};
        if (cmd.last_step || !took)
        begin
            words_next = words_reg + WORDS_KEPT;
        end
        else
        begin
            words_next = words_reg + WORDS_TAKEN;
        end
    end

    // Sign fixup and late overflow check
    always_comb
    begin
        neg_quo = 16'd0 - quo_reg;
        neg_rem = 16'd0 - rem_reg;
        unique case ({dvs_neg_reg, dvd_neg_reg})
            2'b00:
            begin
                words_fix = words_reg + FIX_PP;
                late_ovf  = quo_reg[15];
                res_q     = quo_reg;
                res_r     = rem_reg;
            end
            2'b01:
            begin
                words_fix = words_reg + FIX_PN;
                late_ovf  = (neg_quo != 16'd0) && !neg_quo[15];
                res_q     = neg_quo;
                res_r     = neg_rem;
            end
            2'b11:
            begin
                words_fix = words_reg + FIX_NX;
                late_ovf  = quo_reg[15];
                res_q     = quo_reg;
                res_r     = neg_rem;
            end
            default:
            begin
                words_fix = words_reg + FIX_NX;
                late_ovf  = (neg_quo != 16'd0) && !neg_quo[15];
                res_q     = neg_quo;
                res_r     = rem_reg;
            end
        endcase
    end

    // Select the finished word
    always_comb
    begin
        fin_next = fin_reg;
        if (cmd.finish_early)
        begin
            fin_next.result_word       = dvd_reg;
            fin_next.quotient_negative = 1'b0;
            fin_next.quotient_zero     = 1'b0;
            if (status.dvs_zero)
            begin
                fin_next.outcome     = OUT_TRAP;
                fin_next.cycle_count = TRAP_COUNT;
            end
            else
            begin
                fin_next.outcome     = OUT_OVERFLOW;
                fin_next.cycle_count = {words_reg + WORDS_OVF, 1'b0};
            end
        end
        else if (cmd.finish_loop)
        begin
            fin_next.cycle_count = {words_fix, 1'b0};
            if (late_ovf)
            begin
                fin_next.result_word       = dvd_reg;
                fin_next.outcome           = OUT_OVERFLOW;
                fin_next.quotient_negative = 1'b0;
                fin_next.quotient_zero     = 1'b0;
            end
            else
            begin
                fin_next.result_word       = {res_r, res_q};
                fin_next.outcome           = OUT_DONE;
                fin_next.quotient_negative = res_q[15];
                fin_next.quotient_zero     = (res_q == 16'd0);
            end
        end
    end

    assign status.dvs_zero  = (dvs_reg == 16'd0);
    assign status.early_ovf = (rem_reg >= mag_dvs_reg);

    // Operand, loop and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_reg <= in_data.dividend;
            dvs_reg <= in_data.divisor;
        end
        if (cmd.setup)
        begin
            dvd_neg_reg <= dvd_reg[31];
            dvs_neg_reg <= dvs_reg[15];
            mag_dvs_reg <= dvs_reg[15] ? (16'd0 - dvs_reg) : dvs_reg;
            rem_reg     <= mag_dvd[31:16];
            quo_reg     <= mag_dvd[15:0];
            words_reg   <= dvd_reg[31] ? WORDS_NEG : WORDS_POS;
        end
        else if (cmd.step)
        begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            words_reg <= words_next;
        end
        fin_reg <= fin_next;
        if (cmd.emit)
        begin
            out_reg <= fin_reg;
        end
    end

    assign out_data = out_reg;

    // Partial remainder stays below the divisor magnitude
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.step) |-> (rem_reg < mag_dvs_reg))
        else $error("partial remainder not below divisor");

    // Flags only on a completed division
    a_flags_done: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.finish_early || cmd.finish_loop) && (fin_reg.outcome != OUT_DONE)
        |-> (!fin_reg.quotient_negative && !fin_reg.quotient_zero))
        else $error("quotient flags set without completion");

    // Trap and early overflow return the dividend
    a_early_word: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.finish_early) |-> (fin_reg.result_word == dvd_reg))
        else $error("early exit lost the dividend");

endmodule

/* design/sdiv_controller.sv */
module sdiv_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  sdiv_pkg::status_t status,
    output sdiv_pkg::cmd_t    cmd
);
    import sdiv_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_CHECK = 6'b000100,
        S_LOOP  = 6'b001000,
        S_FIX   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              early_exit;

    assign out_free   = !out_valid_reg || out_ready;
    assign early_exit = status.dvs_zero || status.early_ovf;

    // Sequence the division
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                step_next = '0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (early_exit)
                begin
                    cmd.finish_early = 1'b1;
                    state_next       = S_EMIT;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                cmd.step      = 1'b1;
                cmd.last_step = (step_reg == LAST_STEP);
                step_next     = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                cmd.finish_loop = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid: set on emit, drop when taken
    always_comb
    begin
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Loop always starts from step zero
    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SETUP) |-> (step_reg == '0))
        else $error("loop counter not cleared");

    // Last loop step leads to fixup
    a_loop_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOP) && (step_reg == LAST_STEP) |=> (state_reg == S_FIX))
        else $error("loop did not end after last step");

    // Never overwrite a pending output word
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("output word overwritten");

endmodule

/* design/signed_divide_32_by_16_microcoded.sv */
// Signed 32 by 16 division with an emulated cycle count. Each input word
// (dividend, divisor) produces one output word: remainder in the upper half
// and quotient in the lower half on completion, or the unchanged dividend
// with outcome overflow or division-by-zero trap. The block works on one
// word at a time. For a division that runs the loop, the output word is
// valid after setup, check, sixteen shift-subtract steps at one quotient
// bit per cycle, sign fixup and output load. A trap or early overflow
// skips the loop and goes from the check straight to the output load. A
// new input word is taken as soon as the output register has been loaded,
// even while that result still waits to be taken. The cycle_count field is
// not this block's latency: it reports the emulated cost, twice the number
// of microwords. While the previous result still waits in the output
// register, the output load holds until that result is taken.
module signed_divide_32_by_16_microcoded (
    input  logic       clk,
    input  logic       rst_n,
    sdiv_in_if.sink    in_ch,
    sdiv_out_if.source out_ch
);
    import sdiv_pkg::*;

    cmd_t    cmd;
    status_t status;

    sdiv_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sdiv_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (in_ch.data),
        .out_data (out_ch.data)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
    import sdiv_pkg::*;

    // Emulated cost of the division sequence, in microwords and cycles
    localparam int unsigned CYC_PER_WORD    = 2;
    localparam int unsigned TRAP_CYCLES     = 4;
    localparam int unsigned SETUP_POS       = 6;
    localparam int unsigned SETUP_NEG       = 7;
    localparam int unsigned EARLY_OVF_WORDS = 2;
    localparam int unsigned LOOP_TAKEN      = 3;
    localparam int unsigned LOOP_KEPT       = 4;
    localparam int unsigned FIXUP_PP        = 5;
    localparam int unsigned FIXUP_NP        = 7;
    localparam int unsigned FIXUP_OTHER     = 6;
    localparam int unsigned QUOTIENT_BITS   = 16;

    localparam int RESET_CYCLES     = 8;
    localparam int BULK_WORDS       = 1450;
    localparam int TAIL_WORDS       = 300;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int REPORT_LIMIT     = 10;

    logic clk;
    logic rst_n;

    sdiv_in_if  in_ch ();
    sdiv_out_if out_ch ();

    signed_divide_32_by_16_microcoded dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    in_word_t  pending_words[$];
    out_word_t expected_words[$];

    logic in_accepted;
    logic idle_enable;
    logic long_hold_done;
    int   words_accepted;
    int   mismatches;
    int   in_gap;
    int   out_gap;
    int   long_hold_left;
    int   quiet_cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Compute the result word the divider must produce for one input word
    function automatic out_word_t predict_division(in_word_t w);
        logic [31:0] dvd;
        logic [31:0] mag_dvd;
        logic [15:0] dvs;
        logic [15:0] mag_dvs;
        logic [15:0] rem;
        logic [15:0] quo;
        logic [15:0] res_q;
        logic [15:0] res_r;
        logic        dvd_neg;
        logic        dvs_neg;
        logic        took;
        logic        ovf;
        int unsigned words;
        out_word_t   r;
        r = '0;
        r.outcome = OUT_DONE;
        dvd = w.dividend;
        dvs = w.divisor;
        if (dvs == 16'd0)
        begin
            r.result_word = dvd;
            r.outcome = OUT_TRAP;
            r.cycle_count = 8'(TRAP_CYCLES);
            return r;
        end
        dvs_neg = dvs[15];
        dvd_neg = dvd[31];
        mag_dvs = dvs_neg ? -dvs : dvs;
        mag_dvd = dvd_neg ? -dvd : dvd;
        words = dvd_neg ? SETUP_NEG : SETUP_POS;

        // Upper half already too large: quotient cannot fit
        if (mag_dvd[31:16] >= mag_dvs)
        begin
            r.result_word = dvd;
            r.outcome = OUT_OVERFLOW;
            r.cycle_count = 8'((words + EARLY_OVF_WORDS) * CYC_PER_WORD);
            return r;
        end

        // Restoring shift-subtract, one quotient bit per step
        rem = mag_dvd[31:16];
        quo = mag_dvd[15:0];
        for (int i = 0; i < QUOTIENT_BITS; i++)
        begin
            rem = {rem[14:0], quo[15]};
            quo = {quo[14:0], 1'b0};
            took = rem >= mag_dvs;
            if (took)
            begin
                rem = rem - mag_dvs;
                quo[0] = 1'b1;
            end
            words += (i < QUOTIENT_BITS - 1 && took) ? LOOP_TAKEN : LOOP_KEPT;
        end

        // Fix signs: quotient by operand signs, remainder by dividend sign
        case ({dvd_neg, dvs_neg})
            2'b00:
            begin
                words += FIXUP_PP;
                res_q = quo;
                res_r = rem;
                ovf = quo[15];
            end
            2'b10:
            begin
                words += FIXUP_NP;
                res_q = -quo;
                res_r = -rem;
                ovf = res_q != 16'd0 && !res_q[15];
            end
            2'b11:
            begin
                words += FIXUP_OTHER;
                res_q = quo;
                res_r = -rem;
                ovf = quo[15];
            end
            default:
            begin
                words += FIXUP_OTHER;
                res_q = -quo;
                res_r = rem;
                ovf = res_q != 16'd0 && !res_q[15];
            end
        endcase

        if (ovf)
        begin
            r.result_word = dvd;
            r.outcome = OUT_OVERFLOW;
        end
        else
        begin
            r.result_word = {res_r, res_q};
            r.quotient_negative = res_q[15];
            r.quotient_zero = res_q == 16'd0;
        end
        r.cycle_count = 8'(words * CYC_PER_WORD);
        return r;
    endfunction

    // Draw a random word, mostly ones that run the full loop
    function automatic in_word_t random_division();
        in_word_t    w;
        logic [15:0] dvs;
        logic [15:0] mag_dvs;
        logic [31:0] mag;
        int unsigned sel;
        int unsigned upper_lim;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            dvs = 16'd0;
        else if (sel < 15)
        begin
            case ($urandom_range(0, 3))
                0: dvs = 16'h0001;
                1: dvs = 16'hFFFF;
                2: dvs = 16'h7FFF;
                default: dvs = 16'h8000;
            endcase
        end
        else if (sel < 30)
            dvs = 16'($urandom_range(1, 16));
        else
            dvs = 16'($urandom);
        if (sel >= 15 && sel < 30 && $urandom_range(0, 1) == 1)
            dvs = -dvs;
        mag_dvs = dvs[15] ? -dvs : dvs;

        sel = $urandom_range(0, 99);
        if (sel < 65 && mag_dvs != 16'd0)
        begin
            // Keep the upper half below the divisor; the tighter bound fits
            upper_lim = (sel < 35) ? mag_dvs - 1 : (mag_dvs - 1) >> 1;
            mag = {16'($urandom_range(0, upper_lim)), 16'($urandom)};
            w.dividend = ($urandom_range(0, 1) == 1) ? -mag : mag;
        end
        else if (sel < 80)
        begin
            mag = 32'($urandom_range(0, 255));
            w.dividend = ($urandom_range(0, 1) == 1) ? -mag : mag;
        end
        else
            w.dividend = $urandom;
        w.divisor = dvs;
        return w;
    endfunction

    task automatic queue_word(input logic [31:0] dvd, input logic [15:0] dvs);
        in_word_t w;
        w.dividend = dvd;
        w.divisor = dvs;
        pending_words.push_back(w);
    endtask

    // Hold the sender until every word is taken and every result is back
    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_words.size() != 0 || in_ch.valid)
            @(posedge clk);
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch in %s: expected %h, got %h", field, want, got);
        end
    endtask

    // Driver: present the next pending word, with random idle bursts
    always @(negedge clk)
    begin : feed
        logic     next_valid;
        in_word_t next_data;
        next_valid = in_ch.valid;
        next_data = in_ch.data;
        if (rst_n)
        begin
            if (in_accepted)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (in_gap != 0)
                    in_gap--;
                else if (idle_enable && $urandom_range(0, 7) == 0)
                    in_gap = $urandom_range(0, 7);
                else if (pending_words.size() != 0)
                begin
                    next_data = pending_words.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_ch.valid <= next_valid;
            in_ch.data <= next_data;
        end
    end

    // Receiver: random stalls, plus one long hold to back the block up
    always @(negedge clk)
    begin : drain
        if (rst_n)
        begin
            if (!long_hold_done && words_accepted >= LONG_HOLD_AT)
            begin
                long_hold_left = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (long_hold_left != 0)
            begin
                long_hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (out_gap != 0)
            begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                out_gap = $urandom_range(0, 7);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Monitor: check results in order, predict accepted words, watch for hangs
    always @(posedge clk)
    begin : check
        out_word_t want;
        logic      out_accepted;
        in_accepted = rst_n && in_ch.valid && in_ch.ready;
        out_accepted = rst_n && out_ch.valid && out_ch.ready;
        if (out_accepted)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word %h", out_ch.data);
            end
            else
            begin
                want = expected_words.pop_front();
                report_field("result_word", want.result_word, out_ch.data.result_word);
                report_field("outcome", 32'(want.outcome), 32'(out_ch.data.outcome));
                report_field("quotient_negative", 32'(want.quotient_negative),
                             32'(out_ch.data.quotient_negative));
                report_field("quotient_zero", 32'(want.quotient_zero),
                             32'(out_ch.data.quotient_zero));
                report_field("cycle_count", 32'(want.cycle_count),
                             32'(out_ch.data.cycle_count));
            end
        end
        if (in_accepted)
        begin
            expected_words.push_back(predict_division(in_ch.data));
            words_accepted++;
        end
        if (rst_n)
        begin
            if (in_accepted || out_accepted)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL signed_divide_32_by_16_microcoded");
                $finish;
            end
        end
    end

    // Stimulus: directed corners, random bulk with stalls, random tail without
    initial
    begin : stimulus
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        in_accepted = 1'b0;
        idle_enable = 1'b1;
        long_hold_done = 1'b0;
        words_accepted = 0;
        mismatches = 0;
        in_gap = 0;
        out_gap = 0;
        long_hold_left = 0;
        quiet_cycles = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Division by zero with both dividend signs
        queue_word(32'h1234_5678, 16'h0000);
        queue_word(32'h8000_0000, 16'h0000);
        // Early overflow at the extremes
        queue_word(32'h7FFF_FFFF, 16'h0001);
        queue_word(32'h8000_0000, 16'hFFFF);
        queue_word(32'h8000_0000, 16'h8000);
        queue_word(32'h7FFF_FFFF, 16'h7FFF);
        // Zero and small quotients, remainder signs in every quadrant
        queue_word(32'h0000_0000, 16'h0001);
        queue_word(32'd7, 16'd2);
        queue_word(-32'sd7, 16'd2);
        queue_word(32'd7, -16'sd2);
        queue_word(-32'sd7, -16'sd2);
        // Zero remainder after negation
        queue_word(-32'sd4, 16'd2);
        // Largest positive quotient, then late overflow along each sign path
        queue_word(32'd98301, 16'd3);
        queue_word(32'd98304, 16'd3);
        queue_word(-32'sd98304, -16'sd3);
        queue_word(-32'sd98307, 16'd3);
        queue_word(32'd98307, -16'sd3);
        // Quotient of -32768 with differing signs
        queue_word(-32'sd98304, 16'd3);
        queue_word(32'd98304, -16'sd3);
        // Most negative divisor
        queue_word(32'h3FFF_FFFF, 16'h8000);
        queue_word(32'h4000_0000, 16'h8000);
        queue_word(32'hC000_0000, 16'h8000);
        // Unit divisors and full-width loops
        queue_word(32'hFFFF_FFFF, 16'h0001);
        queue_word(32'h0000_0001, 16'hFFFF);
        queue_word(32'h7FFE_FFFF, 16'h7FFF);
        wait_drained();

        repeat (BULK_WORDS) pending_words.push_back(random_division());
        wait_drained();

        @(posedge clk);
        idle_enable = 1'b0;
        repeat (TAIL_WORDS) pending_words.push_back(random_division());
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASS signed_divide_32_by_16_microcoded");
        else
            $display("FAIL signed_divide_32_by_16_microcoded");
        $finish;
    end

endmodule
